// File: sv/rlpenc_pkg.sv
package rlpenc_pkg;

  localparam int LIST_BUFFER_BYTES_DEF = 256;

  localparam logic [2:0] FUNC_VALUE  = 3'd0;
  localparam logic [2:0] FUNC_STRING = 3'd1;
  localparam logic [2:0] FUNC_WIDE   = 3'd2;
  localparam logic [2:0] FUNC_BEGIN  = 3'd3;
  localparam logic [2:0] FUNC_END    = 3'd4;

  localparam logic [1:0] ERR_OK       = 2'd0;
  localparam logic [1:0] ERR_NESTED   = 2'd1;
  localparam logic [1:0] ERR_OUTSIDE  = 2'd2;
  localparam logic [1:0] ERR_OVERFLOW = 2'd3;

  typedef struct packed {
    logic [2:0]  func;
    logic [63:0] value;
    logic [7:0]  data_byte;
    logic [31:0] string_length;
    logic        string_first;
  } in_item_t;

  typedef struct packed {
    logic [63:0] out_word;
    logic [3:0]  byte_count;
    logic        last;
    logic [1:0]  error_code;
  } out_item_t;

  typedef enum logic [1:0] {
    CL_NONE = 2'd0,
    CL_TOK  = 2'd1,
    CL_ERR  = 2'd2,
    CL_END  = 2'd3
  } cls_t;

  typedef struct packed {
    logic load;
    logic tok_step;
    logic drain_step;
    logic err_emit;
    logic rd_first;
  } ctrl_cmd_t;

  typedef struct packed {
    cls_t cls;
    logic slot_free;
    logic to_buf;
    logic end_mode;
    logic tok_last;
    logic drain_last;
    logic fill_zero;
    logic drop_now;
  } dp_status_t;

endpackage

// File: sv/rlpenc_ram.sv
module rlpenc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: sv/rlpenc_ctrl.sv
module rlpenc_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  rlpenc_pkg::dp_status_t st,
  output rlpenc_pkg::ctrl_cmd_t  cmd
);
  import rlpenc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_TOK   = 4'b0010,
    S_DRAIN = 4'b0100,
    S_ERR   = 4'b1000
  } state_t;

  state_t state, state_next;
  logic   go;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    go = 1'b0;
    case (state)
      S_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) begin
          case (st.cls)
            CL_TOK, CL_END: state_next = S_TOK;
            CL_ERR:         state_next = S_ERR;
            default:        state_next = S_IDLE;
          endcase
        end
      end
      S_TOK: begin
        go = st.to_buf || st.slot_free;
        cmd.tok_step = go;
        cmd.rd_first = 1'b1;
        if (go && st.tok_last) begin
          if (st.to_buf) begin
            state_next = st.drop_now ? S_ERR : S_IDLE;
          end else if (st.end_mode && !st.fill_zero) begin
            state_next = S_DRAIN;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_DRAIN: begin
        cmd.drain_step = st.slot_free;
        if (st.slot_free && st.drain_last) begin
          state_next = S_IDLE;
        end
      end
      S_ERR: begin
        cmd.err_emit = st.slot_free;
        if (st.slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: sv/rlpenc_dp.sv
module rlpenc_dp #(
  parameter int LIST_BUFFER_BYTES = rlpenc_pkg::LIST_BUFFER_BYTES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  rlpenc_pkg::in_item_t                 in_item,
  input  rlpenc_pkg::ctrl_cmd_t                cmd,
  output rlpenc_pkg::dp_status_t               st,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output rlpenc_pkg::out_item_t                out_item,
  output logic                                 wr_en,
  output logic [$clog2(LIST_BUFFER_BYTES)-1:0] wr_addr,
  output logic [7:0]                           wr_data,
  output logic                                 rd_en,
  output logic [$clog2(LIST_BUFFER_BYTES)-1:0] rd_addr,
  input  logic [7:0]                           rd_data
);
  import rlpenc_pkg::*;

  localparam int AW = $clog2(LIST_BUFFER_BYTES);
  localparam int FW = $clog2(LIST_BUFFER_BYTES + 1);
  localparam logic [FW-1:0] FULL = FW'(LIST_BUFFER_BYTES);

  function automatic logic [3:0] be_len64(input logic [63:0] v);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < 8; i++) begin
      if ((v >> (8 * i)) != 64'd0) n = 4'(i + 1);
    end
    return n;
  endfunction

  function automatic logic [2:0] be_len32(input logic [31:0] v);
    logic [2:0] n;
    n = 3'd0;
    for (int i = 0; i < 4; i++) begin
      if ((v >> (8 * i)) != 32'd0) n = 3'(i + 1);
    end
    return n;
  endfunction

  logic          in_list;
  logic [FW-1:0] fill;
  logic          ovf;
  logic [31:0]   srem;
  logic [4:0]    wpos;
  logic          wseen;
  logic [7:0]    tb [9];
  logic [3:0]    tcnt;
  logic [3:0]    tidx;
  logic          to_buf;
  logic          end_mode;
  logic          drop;
  logic [1:0]    err;
  logic [FW-1:0] ridx;
  logic [63:0]   pw;
  logic [2:0]    pwc;

  logic [7:0]    nb [9];
  logic [3:0]    ncnt;
  cls_t          cls;
  logic [1:0]    errn;
  logic [31:0]   srem_next;
  logic [4:0]    wpos_next;
  logic          wseen_next;
  logic          act;
  logic [3:0]    vn;
  logic [63:0]   vs;
  logic [2:0]    ln;
  logic [31:0]   ls;
  logic [31:0]   fill32;
  logic [2:0]    fn;
  logic [31:0]   fs;
  logic [5:0]    wlen;
  logic [7:0]    b;

  logic [FW-1:0] ridx_p1;
  logic [7:0]    tbyte;
  logic          tok_final;
  logic          pushing;
  logic [7:0]    pbyte;
  logic          pfinal;
  logic [63:0]   merged;
  logic [3:0]    nc;
  logic          emit;

  assign b      = in_item.data_byte;
  assign vn     = be_len64(in_item.value);
  assign vs     = in_item.value << {(4'd8 - vn), 3'b000};
  assign ln     = be_len32(in_item.string_length);
  assign ls     = in_item.string_length << {(3'd4 - ln), 3'b000};
  assign fill32 = 32'(fill);
  assign fn     = be_len32(fill32);
  assign fs     = fill32 << {(3'd4 - fn), 3'b000};
  assign wlen   = 6'd32 - {1'b0, wpos};

  always_comb begin
    for (int i = 0; i < 9; i++) nb[i] = 8'h00;
    ncnt = 4'd0;
    cls = CL_NONE;
    errn = ERR_OK;
    srem_next = srem;
    wpos_next = wpos;
    wseen_next = wseen;
    act = 1'b0;
    case (in_item.func)
      FUNC_VALUE: begin
        act = 1'b1;
        if (vn == 4'd1 && in_item.value < 64'h80) begin
          nb[0] = in_item.value[7:0];
          ncnt = 4'd1;
        end else begin
          nb[0] = 8'h80 + {4'b0, vn};
          for (int i = 0; i < 8; i++) nb[i + 1] = vs[63 - 8 * i -: 8];
          ncnt = vn + 4'd1;
        end
      end
      FUNC_STRING: begin
        if (in_item.string_first) begin
          act = 1'b1;
          if (in_item.string_length == 32'd0) begin
            nb[0] = 8'h80;
            ncnt = 4'd1;
            srem_next = 32'd0;
          end else begin
            srem_next = in_item.string_length - 32'd1;
            if (in_item.string_length == 32'd1 && b < 8'h80) begin
              nb[0] = b;
              ncnt = 4'd1;
            end else if (in_item.string_length <= 32'd55) begin
              nb[0] = 8'h80 + in_item.string_length[7:0];
              nb[1] = b;
              ncnt = 4'd2;
            end else begin
              nb[0] = 8'hB7 + {5'b0, ln};
              for (int i = 0; i < 4; i++) nb[i + 1] = ls[31 - 8 * i -: 8];
              for (int j = 1; j < 6; j++) begin
                if (4'(j) == {1'b0, ln} + 4'd1) nb[j] = b;
              end
              ncnt = {1'b0, ln} + 4'd2;
            end
          end
        end else if (srem != 32'd0) begin
          act = 1'b1;
          nb[0] = b;
          ncnt = 4'd1;
          srem_next = srem - 32'd1;
        end
      end
      FUNC_WIDE: begin
        act = 1'b1;
        if (wseen) begin
          nb[0] = b;
          ncnt = 4'd1;
        end else if (b != 8'h00) begin
          if (wlen == 6'd1 && b < 8'h80) begin
            nb[0] = b;
            ncnt = 4'd1;
          end else begin
            nb[0] = 8'h80 + {2'b0, wlen};
            nb[1] = b;
            ncnt = 4'd2;
          end
          wseen_next = 1'b1;
        end else if (wpos == 5'd31) begin
          nb[0] = 8'h80;
          ncnt = 4'd1;
        end
        if (wpos == 5'd31) begin
          wpos_next = 5'd0;
          wseen_next = 1'b0;
        end else begin
          wpos_next = wpos + 5'd1;
        end
      end
      FUNC_BEGIN: begin
        if (in_list) begin
          cls = CL_ERR;
          errn = ERR_NESTED;
        end
      end
      FUNC_END: begin
        if (!in_list) begin
          cls = CL_ERR;
          errn = ERR_OUTSIDE;
        end else begin
          cls = CL_END;
          errn = ovf ? ERR_OVERFLOW : ERR_OK;
          if (fill32 <= 32'd55) begin
            nb[0] = 8'hC0 + fill32[7:0];
            ncnt = 4'd1;
          end else begin
            nb[0] = 8'hF7 + {5'b0, fn};
            for (int i = 0; i < 4; i++) nb[i + 1] = fs[31 - 8 * i -: 8];
            ncnt = {1'b0, fn} + 4'd1;
          end
        end
      end
      default: act = 1'b0;
    endcase
    if (act) begin
      if (ncnt != 4'd0) begin
        cls = CL_TOK;
        errn = in_list ? ERR_OVERFLOW : ERR_OK;
      end else if (!in_list) begin
        cls = CL_ERR;
        errn = ERR_OK;
      end
    end
  end

  assign ridx_p1   = ridx + FW'(1);
  assign tbyte     = tb[tidx];
  assign tok_final = (tidx == tcnt - 4'd1) && !(end_mode && fill != '0);

  assign st.cls        = cls;
  assign st.slot_free  = !out_valid || out_ready;
  assign st.to_buf     = to_buf;
  assign st.end_mode   = end_mode;
  assign st.tok_last   = (tidx == tcnt - 4'd1);
  assign st.drain_last = (ridx_p1 == fill);
  assign st.fill_zero  = (fill == '0);
  assign st.drop_now   = drop || (fill == FULL);

  assign wr_en   = cmd.tok_step && to_buf && (fill != FULL);
  assign wr_addr = fill[AW-1:0];
  assign wr_data = tbyte;
  assign rd_en   = cmd.rd_first || cmd.drain_step;
  assign rd_addr = cmd.rd_first ? '0 : ridx_p1[AW-1:0];

  assign pushing = (cmd.tok_step && !to_buf) || cmd.drain_step;
  assign pbyte   = cmd.drain_step ? rd_data : tbyte;
  assign pfinal  = cmd.drain_step ? st.drain_last : tok_final;
  assign merged  = pw | ({56'b0, pbyte} << {(3'd7 - pwc), 3'b000});
  assign nc      = {1'b0, pwc} + 4'd1;
  assign emit    = pushing && (nc == 4'd8 || pfinal);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_list   <= 1'b0;
      fill      <= '0;
      ovf       <= 1'b0;
      srem      <= 32'd0;
      wpos      <= 5'd0;
      wseen     <= 1'b0;
      pw        <= 64'd0;
      pwc       <= 3'd0;
      out_valid <= 1'b0;
      tcnt      <= 4'd0;
      tidx      <= 4'd0;
      to_buf    <= 1'b0;
      end_mode  <= 1'b0;
      drop      <= 1'b0;
      ridx      <= '0;
      err       <= ERR_OK;
    end else begin
      if (cmd.load) begin
        for (int i = 0; i < 9; i++) tb[i] <= nb[i];
        tcnt     <= ncnt;
        tidx     <= 4'd0;
        ridx     <= '0;
        err      <= errn;
        drop     <= 1'b0;
        srem     <= srem_next;
        wpos     <= wpos_next;
        wseen    <= wseen_next;
        to_buf   <= in_list && (cls == CL_TOK);
        end_mode <= (cls == CL_END);
        if (in_item.func == FUNC_BEGIN && !in_list) begin
          in_list <= 1'b1;
          fill    <= '0;
          ovf     <= 1'b0;
        end
        if (cls == CL_END) begin
          in_list <= 1'b0;
        end
      end
      if (cmd.tok_step) begin
        tidx <= tidx + 4'd1;
        if (to_buf) begin
          if (fill != FULL) begin
            fill <= fill + FW'(1);
          end else begin
            ovf  <= 1'b1;
            drop <= 1'b1;
          end
        end else if (end_mode && st.tok_last && fill == '0) begin
          ovf <= 1'b0;
        end
      end
      if (cmd.drain_step) begin
        ridx <= ridx_p1;
        if (st.drain_last) begin
          fill <= '0;
          ovf  <= 1'b0;
        end
      end
      if (pushing) begin
        if (emit) begin
          pw  <= 64'd0;
          pwc <= 3'd0;
        end else begin
          pw  <= merged;
          pwc <= pwc + 3'd1;
        end
      end
      if (emit || cmd.err_emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_item <= '{out_word: merged, byte_count: nc, last: pfinal, error_code: err};
    end else if (cmd.err_emit) begin
      out_item <= '{out_word: 64'd0, byte_count: 4'd0, last: 1'b1, error_code: err};
    end
  end

endmodule

// File: sv/rlp_item_encoder.sv
// channel | signals                          | payload
// input   | in_valid, in_ready, in_item      | func, value, data_byte, string_length,
//         |                                  | string_first
// output  | out_valid, out_ready, out_item   | out_word, byte_count, last, error_code
//
// an item is accepted and then sent as its encoded bytes (1 to 9); an empty or error result
// is sent as one word and an ignored item sends nothing; inside a list bytes go to the buffer
// end list sends 1 to 3 prefix bytes then list bytes, one buffer read per unstalled cycle
// in_ready is high only when no earlier item is still being worked on
// the output register lets the next item be accepted while a result waits
// output stalls hold the packer; synchronous reset empties the list state
module rlp_item_encoder #(
  parameter int LIST_BUFFER_BYTES = rlpenc_pkg::LIST_BUFFER_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  rlpenc_pkg::in_item_t  in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output rlpenc_pkg::out_item_t out_item
);
  import rlpenc_pkg::*;

  localparam int AW = $clog2(LIST_BUFFER_BYTES);

  ctrl_cmd_t  cmd;
  dp_status_t st;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;

  rlpenc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  rlpenc_dp #(
    .LIST_BUFFER_BYTES (LIST_BUFFER_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  rlpenc_ram #(
    .WIDTH (8),
    .DEPTH (LIST_BUFFER_BYTES)
  ) u_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

// File: sv/rlpenc_checker.sv
module rlpenc_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input rlpenc_pkg::out_item_t out_item
);

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid)
    else $error("input item dropped while waiting");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.byte_count <= 4'd8)
    else $error("byte count above eight");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.byte_count == 4'd0 |-> out_item.last && out_item.out_word == 64'd0)
    else $error("empty result not final or not zero");

  a_partial_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.byte_count < 4'd8 |-> out_item.last)
    else $error("partial word not final");

endmodule

bind rlp_item_encoder rlpenc_checker u_rlpenc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
